>>> hw/rtl/mmlp_pkg.sv
// shared types, constants and microcode program for the min/max load partition block
package mmlp_pkg;

  // fixed field widths of the block's ports and of its group counter
  localparam int WEIGHT_W = 16;
  localparam int LIMIT_W  = 16;
  localparam int CAP_W    = 26;
  localparam int GROUP_W  = 17;

  // sequencer program counter
  localparam int PC_W = 3;

  localparam logic [PC_W-1:0] PC_LOAD  = 3'd0;
  localparam logic [PC_W-1:0] PC_INIT  = 3'd1;
  localparam logic [PC_W-1:0] PC_PROBE = 3'd2;
  localparam logic [PC_W-1:0] PC_SCAN  = 3'd3;
  localparam logic [PC_W-1:0] PC_EMIT  = 3'd4;

  // datapath operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_INIT  = 3'd2;
  localparam logic [2:0] OP_PROBE = 3'd3;
  localparam logic [2:0] OP_SCAN  = 3'd4;
  localparam logic [2:0] OP_EMIT  = 3'd5;

  // jump conditions
  localparam logic [2:0] COND_ALWAYS   = 3'd0;
  localparam logic [2:0] COND_IN_LAST  = 3'd1;
  localparam logic [2:0] COND_BOUNDS   = 3'd2;
  localparam logic [2:0] COND_SCAN_END = 3'd3;
  localparam logic [2:0] COND_OUT_FREE = 3'd4;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic            hold;    // stay on this step while the condition is false
    logic [PC_W-1:0] target;  // jump target when the condition is true
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_IN_LAST,  hold: 1'b1, target: PC_INIT};
      PC_INIT:  w = '{op: OP_INIT,  cond: COND_ALWAYS,   hold: 1'b0, target: PC_PROBE};
      PC_PROBE: w = '{op: OP_PROBE, cond: COND_BOUNDS,   hold: 1'b0, target: PC_EMIT};
      PC_SCAN:  w = '{op: OP_SCAN,  cond: COND_SCAN_END, hold: 1'b1, target: PC_PROBE};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_FREE, hold: 1'b1, target: PC_LOAD};
      default:  w = '{op: OP_NOP,   cond: COND_ALWAYS,   hold: 1'b0, target: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/mmlp_ram.sv
// generic single write port, single read port ram with registered read
module mmlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/min_max_load_partition_top.sv
// min/max load partition: microcoded binary search for the smallest group capacity
//
// usage
//   weight channel: weight_valid/weight_stall carry one item per cycle (weight, is_last)
//   while the block is loading; items go into a weight store of STORE_DEPTH entries,
//   the running sum and the largest weight are kept on the fly
//   items past STORE_DEPTH are discarded and flagged in dropped_items
//   the item with is_last high ends the set and starts the search; weight_stall
//   stays high from then until the result is handed to the output register
//   result channel: result_valid/result_stall carry min_capacity and dropped_items,
//   one result per set; the output register lets the next set load while a result
//   waits to be taken
//   after the last item: an init step, then for each probe a probe step plus a scan of
//   up to n stored items (one stored item per cycle from the store's read port,
//   cut short at the first item that breaks the limit), a final probe step and
//   an emit step; probes <= ceil(log2(sum - max + 1))
//   cfg_wr_en/cfg_wr_data write group_limit (0 acts as 1); write only when idle
//   reset: group_limit back to 1, set counters cleared, no result pending
//   when result_stall holds a result and the next set's search ends, the
//   sequencer waits in its emit step until the output register frees up
module min_max_load_partition_top #(
  parameter int STORE_DEPTH = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mmlp_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                          weight_valid,
  output logic                          weight_stall,
  input  logic [mmlp_pkg::WEIGHT_W-1:0] weight,
  input  logic                          is_last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [mmlp_pkg::CAP_W-1:0]    min_capacity,
  output logic                          dropped_items
);

  import mmlp_pkg::*;

  // stored weight width, sum width, counter and address widths
  localparam int WB    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int SUM_W = WB + CNT_W;

  // sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          ucode;
  logic            cond_true;

  // configuration
  logic [LIMIT_W-1:0] group_limit;
  logic [LIMIT_W-1:0] limit_eff;

  // set accumulation
  logic [CNT_W-1:0] item_count;
  logic [SUM_W-1:0] weight_total;
  logic [WB-1:0]    largest_weight;
  logic             overflow_seen;

  // search datapath
  logic [SUM_W-1:0]   search_low;
  logic [SUM_W-1:0]   search_high;
  logic [SUM_W-1:0]   mid;
  logic [SUM_W-1:0]   mid_next;
  logic [SUM_W-1:0]   group_load;
  logic [GROUP_W-1:0] group_count;
  logic [CNT_W-1:0]   scan_index;

  logic             in_accept;
  logic [WB-1:0]    w_in;
  logic             store_room;

  logic [WB-1:0]      w_rd;
  logic [AW-1:0]      rd_addr;
  logic [CNT_W-1:0]   scan_inc;
  logic [SUM_W:0]     load_try;
  logic               load_fits;
  logic [SUM_W-1:0]   load_next;
  logic [GROUP_W-1:0] groups_next;
  logic               scan_fail;
  logic               scan_end;
  logic               bounds_met;
  logic               out_free;
  logic               emit_fire;

  logic [SUM_W+CAP_W-1:0] cap_ext;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      group_limit <= LIMIT_W'(1);
    end else if (cfg_wr_en) begin
      group_limit <= cfg_wr_data;
    end
  end

  assign limit_eff = (group_limit == '0) ? LIMIT_W'(1) : group_limit;

  // ---------------------------------------------------------------------------
  // control word fetch and jump logic
  // ---------------------------------------------------------------------------
  assign ucode = ucode_rom(pc);

  // only the load step takes items
  assign weight_stall = (ucode.op != OP_LOAD);
  assign in_accept    = weight_valid && !weight_stall;
  assign w_in         = weight[WB-1:0];
  assign store_room   = (item_count < CNT_W'(STORE_DEPTH));

  assign out_free  = !result_valid || !result_stall;
  assign emit_fire = (ucode.op == OP_EMIT) && out_free;

  assign bounds_met = (search_low >= search_high);

  always_comb begin
    case (ucode.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN_LAST:  cond_true = in_accept && is_last;
      COND_BOUNDS:   cond_true = bounds_met;
      COND_SCAN_END: cond_true = scan_end;
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_next = ucode.target;
    end else if (ucode.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------------------------
  // weight store: written while loading, read one entry ahead while scanning
  // ---------------------------------------------------------------------------
  assign scan_inc = scan_index + CNT_W'(1);
  assign rd_addr  = (ucode.op == OP_SCAN) ? scan_inc[AW-1:0] : '0;

  mmlp_ram #(
    .WIDTH (WB),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_accept && store_room),
    .wr_addr (item_count[AW-1:0]),
    .wr_data (w_in),
    .rd_addr (rd_addr),
    .rd_data (w_rd)
  );

  // ---------------------------------------------------------------------------
  // greedy fill step for the stored item at scan_index
  // ---------------------------------------------------------------------------
  assign mid_next    = search_low + ((search_high - search_low) >> 1);
  assign load_try    = {1'b0, group_load} + (SUM_W+1)'(w_rd);
  assign load_fits   = (load_try <= {1'b0, mid});
  assign load_next   = load_fits ? load_try[SUM_W-1:0] : SUM_W'(w_rd);
  assign groups_next = load_fits ? group_count : group_count + GROUP_W'(1);
  // an item above the capacity or one group too many ends the scan as a miss
  assign scan_fail   = (SUM_W'(w_rd) > mid) || (groups_next > GROUP_W'(limit_eff));
  assign scan_end    = scan_fail || (scan_inc == item_count);

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count     <= '0;
      weight_total   <= '0;
      largest_weight <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      case (ucode.op)
        OP_LOAD: begin
          if (in_accept) begin
            if (store_room) begin
              item_count   <= item_count + CNT_W'(1);
              weight_total <= weight_total + SUM_W'(w_in);
              if (w_in > largest_weight) begin
                largest_weight <= w_in;
              end
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            item_count     <= '0;
            weight_total   <= '0;
            largest_weight <= '0;
            overflow_seen  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ucode.op)
      OP_INIT: begin
        search_low  <= SUM_W'(largest_weight);
        search_high <= weight_total;
      end
      OP_PROBE: begin
        mid         <= mid_next;
        group_load  <= '0;
        group_count <= GROUP_W'(1);
        scan_index  <= '0;
      end
      OP_SCAN: begin
        group_load  <= load_next;
        group_count <= groups_next;
        scan_index  <= scan_inc;
        if (scan_end) begin
          if (scan_fail) begin
            search_low <= mid + SUM_W'(1);
          end else begin
            search_high <= mid;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  assign cap_ext = (SUM_W+CAP_W)'(search_low);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      min_capacity  <= cap_ext[CAP_W-1:0];
      dropped_items <= overflow_seen;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a scan in progress never carries more groups than allowed
  a_groups_in_limit: assert property (@(posedge clk) disable iff (rst)
    (ucode.op == OP_SCAN) |-> (group_count <= GROUP_W'(limit_eff)))
    else $error("group count above limit during scan");

  // the search interval stays ordered while probing and scanning
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    ((ucode.op == OP_PROBE) || (ucode.op == OP_SCAN)) |-> (search_low <= search_high))
    else $error("search bounds crossed");

  // a new result only appears after the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ucode.op == OP_EMIT))
    else $error("result raised outside emit step");

  // the fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(STORE_DEPTH))
    else $error("item count above store depth");

endmodule
